FILE: rtl/brb_pkg.sv
// shared types, field widths and operation codes for the byte ring buffer
package brb_pkg;

   localparam int DATA_W        = 8;
   localparam int OP_W          = 3;
   localparam int COUNT_W       = 13;
   localparam int POS_W         = 12;
   localparam int SIZE_W        = 13;
   localparam int DEPTH_DEFAULT = 4096;
   localparam int SIZE_RESET    = 4096;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [OP_W-1:0] OP_WRITE_BYTE = 3'd0;
   localparam logic [OP_W-1:0] OP_READ_BYTE  = 3'd1;
   localparam logic [OP_W-1:0] OP_WRITE_ADV  = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_ADV   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

   typedef enum logic [2:0] {
      KIND_WRITE_BYTE,
      KIND_READ_BYTE,
      KIND_WRITE_ADV,
      KIND_READ_ADV,
      KIND_CLEAR,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [DATA_W-1:0]  data_byte;
      logic [COUNT_W-1:0] count;
   } brb_req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic [COUNT_W-1:0] done_count;
      logic [COUNT_W-1:0] used_bytes;
      logic [COUNT_W-1:0] free_bytes;
      logic [POS_W-1:0]   write_pos;
      logic [COUNT_W-1:0] write_span;
      logic [POS_W-1:0]   read_pos;
      logic [COUNT_W-1:0] read_span;
   } brb_rsp_type;

   typedef struct packed {
      kind_type           kind;
      logic [DATA_W-1:0]  data_byte;
      logic [COUNT_W-1:0] count;
   } brb_cmd_type;

endpackage

FILE: rtl/brb_ram.sv
// generic simple dual-port ram with registered read
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/brb_front.sv
// front end: takes request words and classifies the operation code
module brb_front import brb_pkg::*; (
   input  logic        start,
   output logic        busy,
   input  brb_req_type req_word,
   input  logic        queue_full,
   output logic        push,
   output brb_cmd_type push_cmd
);

   kind_type kind;

   always_comb begin
      unique case (req_word.op)
         OP_WRITE_BYTE: kind = KIND_WRITE_BYTE;
         OP_READ_BYTE:  kind = KIND_READ_BYTE;
         OP_WRITE_ADV:  kind = KIND_WRITE_ADV;
         OP_READ_ADV:   kind = KIND_READ_ADV;
         OP_CLEAR:      kind = KIND_CLEAR;
         default:       kind = KIND_NONE;
      endcase
   end

   assign busy               = queue_full;
   assign push               = start & ~queue_full;
   assign push_cmd.kind      = kind;
   assign push_cmd.data_byte = req_word.data_byte;
   assign push_cmd.count     = req_word.count;

endmodule

FILE: rtl/brb_queue.sv
// two-entry command queue between front and back
module brb_queue import brb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  brb_cmd_type push_cmd,
   input  logic        pop,
   output brb_cmd_type head,
   output logic        not_empty,
   output logic        full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   brb_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign do_push = push & ~full;
   assign do_pop  = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));

endmodule

FILE: rtl/brb_back.sv
// back end: position and fill bookkeeping, byte store access, status word
module brb_back import brb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  brb_cmd_type       cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata,
   output logic              rsp_strobe,
   output brb_rsp_type       rsp_word
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int AW = (CW > SIZE_W) ? CW : SIZE_W;
   localparam int SIZE_RESET_EFF = (SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET;

   function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] pos,
                                              input logic [CW-1:0] n,
                                              input logic [CW-1:0] sz);
      logic [SW-1:0] sum;
      sum = SW'(pos) + SW'(n);
      if (sum >= SW'(sz)) begin
         sum = sum - SW'(sz);
      end
      return sum[PW-1:0];
   endfunction

   logic [CW-1:0] size_ff, size_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [PW-1:0] wpos_ff, wpos_in;
   logic [PW-1:0] rpos_ff, rpos_in;
   logic          strobe_ff;
   logic          rd_sel_ff, rd_sel_in;
   brb_rsp_type   rsp_ff, rsp_in;

   logic [CW-1:0]     csr_size;
   logic [CW-1:0]     free_cur;
   logic [CW-1:0]     done;
   logic [CW-1:0]     free_nxt;
   logic [CW-1:0]     wgap, rgap;
   logic [CW-1:0]     wspan, rspan;
   logic              ram_we, ram_re;
   logic [DATA_W-1:0] ram_q;

   // size register is kept already saturated to 1..DEPTH
   always_comb begin
      if (csr_wdata == '0) begin
         csr_size = CW'(1);
      end else if (AW'(csr_wdata) > AW'(DEPTH)) begin
         csr_size = CW'(DEPTH);
      end else begin
         csr_size = CW'(csr_wdata);
      end
   end

   assign free_cur = size_ff - fill_ff;
   assign cmd_pop  = cmd_valid;

   always_comb begin
      size_in   = size_ff;
      fill_in   = fill_ff;
      wpos_in   = wpos_ff;
      rpos_in   = rpos_ff;
      done      = '0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      rd_sel_in = 1'b0;
      if (cmd_valid) begin
         unique case (cmd.kind)
            KIND_WRITE_BYTE: begin
               if (free_cur != '0) begin
                  ram_we  = 1'b1;
                  done    = CW'(1);
                  wpos_in = wrap_add(wpos_ff, CW'(1), size_ff);
                  fill_in = fill_ff + CW'(1);
               end
            end
            KIND_READ_BYTE: begin
               if (fill_ff != '0) begin
                  ram_re    = 1'b1;
                  rd_sel_in = 1'b1;
                  done      = CW'(1);
                  rpos_in   = wrap_add(rpos_ff, CW'(1), size_ff);
                  fill_in   = fill_ff - CW'(1);
               end
            end
            KIND_WRITE_ADV: begin
               done    = (AW'(cmd.count) > AW'(free_cur)) ? free_cur : CW'(cmd.count);
               wpos_in = wrap_add(wpos_ff, done, size_ff);
               fill_in = fill_ff + done;
            end
            KIND_READ_ADV: begin
               done    = (AW'(cmd.count) > AW'(fill_ff)) ? fill_ff : CW'(cmd.count);
               rpos_in = wrap_add(rpos_ff, done, size_ff);
               fill_in = fill_ff - done;
            end
            KIND_CLEAR: begin
               wpos_in = '0;
               rpos_in = '0;
               fill_in = '0;
            end
            default: begin
            end
         endcase
      end
      // size write also restarts the buffer, contents stay
      if (csr_we) begin
         size_in = csr_size;
         wpos_in = '0;
         rpos_in = '0;
         fill_in = '0;
      end
   end

   // status after the operation
   assign free_nxt = size_ff - fill_in;
   assign wgap     = size_ff - CW'(wpos_in);
   assign rgap     = size_ff - CW'(rpos_in);
   assign wspan    = (wgap <= free_nxt) ? wgap : free_nxt;
   assign rspan    = (rgap <= fill_in) ? rgap : fill_in;

   always_comb begin
      rsp_in.read_data  = '0;
      rsp_in.done_count = COUNT_W'(done);
      rsp_in.used_bytes = COUNT_W'(fill_in);
      rsp_in.free_bytes = COUNT_W'(free_nxt);
      rsp_in.write_pos  = POS_W'(wpos_in);
      rsp_in.write_span = COUNT_W'(wspan);
      rsp_in.read_pos   = POS_W'(rpos_in);
      rsp_in.read_span  = COUNT_W'(rspan);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= CW'(SIZE_RESET_EFF);
         fill_ff   <= '0;
         wpos_ff   <= '0;
         rpos_ff   <= '0;
         strobe_ff <= 1'b0;
         rd_sel_ff <= 1'b0;
      end else begin
         size_ff   <= size_in;
         fill_ff   <= fill_in;
         wpos_ff   <= wpos_in;
         rpos_ff   <= rpos_in;
         strobe_ff <= cmd_valid;
         rd_sel_ff <= rd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   brb_ram #(
      .WIDTH(DATA_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(wpos_ff),
      .wdata(cmd.data_byte),
      .re   (ram_re),
      .raddr(rpos_ff),
      .rdata(ram_q)
   );

   // read byte lands from the store in the same cycle the word is shown
   always_comb begin
      rsp_word           = rsp_ff;
      rsp_word.read_data = rd_sel_ff ? ram_q : '0;
   end

   assign rsp_strobe = strobe_ff;

endmodule

FILE: rtl/byte_ring_buffer_top.sv
// top level of the circular byte buffer: front, command queue and back
//
// circular byte buffer with a write position, a read position and a fill count.
// each request word is one operation: write byte, read byte, write advance,
// read advance or clear; unknown codes only report status. every accepted word
// gives exactly one response word on rsp_word, marked by rsp_strobe for one
// cycle, after passing the command queue and the response register. the
// receiver cannot hold responses off, and none is needed: one word per clock
// is taken and retired, since the back end finishes each operation at the
// queue head and registers its response word together with the store read.
// busy rises only when the two-entry queue fills; steady traffic never does.
// the buffer size register (csr_wdata) is saturated to 1..DEPTH, and writing
// it clears both positions and the fill count while the stored bytes stay.
// write it only while no response is outstanding. the byte store has no reset;
// reading a byte skipped over by a write advance returns an arbitrary value.
module byte_ring_buffer_top import brb_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request side
   input  logic              start,
   output logic              busy,
   input  brb_req_type       req_word,
   // response side
   output logic              rsp_strobe,
   output brb_rsp_type       rsp_word,
   // buffer size register
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata
);

   // front to queue
   logic        push;
   brb_cmd_type push_cmd;
   logic        queue_full;

   // queue to back
   brb_cmd_type head;
   logic        not_empty;
   logic        pop;

   // a request word is taken on this edge
   logic        accept;

   assign accept = start & ~busy;

   // classify the operation code
   brb_front u_front (
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .queue_full(queue_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // decouples request acceptance from execution
   brb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .not_empty(not_empty),
      .full     (queue_full)
   );

   // bookkeeping, byte store and response register
   brb_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head),
      .cmd_valid (not_empty),
      .cmd_pop   (pop),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word)
   );

   // each accepted word yields its response after the queue and response register
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted word produced no response");

   // no response without a word accepted earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("response without a request");

   // the queue drains every cycle, so it never backs up
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> !busy)
      else $error("command queue filled up");

   // contiguous spans never exceed the totals they are cut from
   a_span_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.write_span <= rsp_word.free_bytes)
                  && (rsp_word.read_span <= rsp_word.used_bytes))
      else $error("span exceeds fill or free total");

endmodule
